/* hw/rtl/cdq_pkg.sv */
// Package for the circular deque: sizes, operation and status codes,
// the per-cell control struct and the ring index step functions.
// No dependencies.
package cdq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int CNT_W   = (CAP_W > IDX_W + 1) ? CAP_W : IDX_W + 1;
   localparam logic [DATA_W-1:0] UNDERFLOW_DATA = {DATA_W{1'b1}};

   typedef enum logic [1:0] {
      KIND_PUSH_BACK  = 2'd0,
      KIND_PUSH_FRONT = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_idx;
      logic [DATA_W-1:0] wr_data;
      logic [IDX_W-1:0]  rd_idx;
   } cell_ctl_type;

   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i,
                                                input logic [IDX_W-1:0] last);
      return (i >= last) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i,
                                                  input logic [CNT_W-1:0] cap,
                                                  input logic [IDX_W-1:0] last);
      return (i == '0 || CNT_W'(i) >= cap) ? last : i - 1'b1;
   endfunction

endpackage

/* hw/rtl/cdq_cell.sv */
// One ring entry of the circular deque. It stores one value and passes the
// read value along the row, replacing it when its own slot is addressed.
// Depends on cdq_pkg.
module cdq_cell
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic [IDX_W-1:0]  slot_idx,
   input  cell_ctl_type      ctl,
   input  logic [DATA_W-1:0] rd_chain_in,
   output logic [DATA_W-1:0] rd_chain_out
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.wr_en && ctl.wr_idx == slot_idx) begin
         data_in = ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rd_chain_out = (ctl.rd_idx == slot_idx) ? data_ff : rd_chain_in;

endmodule

/* hw/rtl/circular_deque.sv */
// Top level of the circular deque: index control, capacity register,
// result register and the row of storage cells.
// Depends on cdq_pkg and cdq_cell.

// A double-ended queue of up to DEPTH 32-bit entries kept in a row of cells.
// Every request transfer is one of push back, push front, pop front or pop
// back and yields exactly one response in the next cycle: the popped value with
// status ok, zero with status ok for a push that is stored, zero with status
// overflow for a push into a full queue, or all ones with status underflow for
// a pop from an empty queue. One request is taken every cycle while the
// response side keeps up and no capacity write is offered. Writing the
// capacity register empties the queue; capacities of zero or above DEPTH act
// as one and DEPTH.
module circular_deque
   import cdq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CAP_W-1:0]  csr_data,    // capacity_in_use
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // value
   input  logic [1:0]        req_tuser,   // kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // data
   output logic [1:0]        rsp_tuser    // status
);

   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [IDX_W-1:0]  front_ff, front_in;
   logic [IDX_W-1:0]  rear_ff, rear_in;
   logic              empty_ff, empty_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic [CNT_W-1:0]  eff_cap;
   logic [IDX_W-1:0]  cap_last;
   logic              accept;
   logic              cfg_write;
   logic              full;
   kind_type          kind;
   logic [IDX_W-1:0]  rear_up, front_up, front_down, rear_down;
   cell_ctl_type      ctl;
   logic [DATA_W-1:0] rd_chain [DEPTH+1];

   always_comb begin
      priority if (cap_ff == '0) begin
         eff_cap = CNT_W'(1);
      end else if (CNT_W'(cap_ff) > CNT_W'(DEPTH)) begin
         eff_cap = CNT_W'(DEPTH);
      end else begin
         eff_cap = CNT_W'(cap_ff);
      end
   end

   assign cap_last   = IDX_W'(eff_cap - 1'b1);
   assign rear_up    = step_up(rear_ff, cap_last);
   assign front_up   = step_up(front_ff, cap_last);
   assign front_down = step_down(front_ff, eff_cap, cap_last);
   assign rear_down  = step_down(rear_ff, eff_cap, cap_last);
   assign full       = !empty_ff && rear_up == front_ff;
   assign kind       = kind_type'(req_tuser);

   assign csr_ready  = 1'b1;
   assign cfg_write  = csr_valid && csr_ready;
   assign req_tready = (!rsp_valid_ff || rsp_tready) && !csr_valid;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cap_in        = cap_ff;
      front_in      = front_ff;
      rear_in       = rear_ff;
      empty_in      = empty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ctl.wr_en     = 1'b0;
      ctl.wr_idx    = '0;
      ctl.wr_data   = req_tdata;
      ctl.rd_idx    = (kind == KIND_POP_FRONT) ? front_ff : rear_ff;
      if (cfg_write) begin
         cap_in   = csr_data;
         front_in = '0;
         rear_in  = '0;
         empty_in = 1'b1;
      end else if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_data_in   = '0;
         rsp_status_in = STATUS_OK;
         unique case (kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
               if (full) begin
                  rsp_status_in = STATUS_OVERFLOW;
               end else if (empty_ff) begin
                  front_in  = '0;
                  rear_in   = '0;
                  empty_in  = 1'b0;
                  ctl.wr_en = 1'b1;
               end else if (kind == KIND_PUSH_BACK) begin
                  rear_in    = rear_up;
                  ctl.wr_en  = 1'b1;
                  ctl.wr_idx = rear_up;
               end else begin
                  front_in   = front_down;
                  ctl.wr_en  = 1'b1;
                  ctl.wr_idx = front_down;
               end
            end
            KIND_POP_FRONT, KIND_POP_BACK: begin
               if (empty_ff) begin
                  rsp_data_in   = UNDERFLOW_DATA;
                  rsp_status_in = STATUS_UNDERFLOW;
               end else begin
                  rsp_data_in = rd_chain[DEPTH];
                  if (front_ff == rear_ff) begin
                     front_in = '0;
                     rear_in  = '0;
                     empty_in = 1'b1;
                  end else if (kind == KIND_POP_FRONT) begin
                     front_in = front_up;
                  end else begin
                     rear_in = rear_down;
                  end
               end
            end
            default: begin
               rsp_status_in = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_W'(DEPTH);
         front_ff     <= '0;
         rear_ff      <= '0;
         empty_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         front_ff     <= front_in;
         rear_ff      <= rear_in;
         empty_ff     <= empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rd_chain[0] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      cdq_cell u_cell (
         .clock        (clock),
         .slot_idx     (IDX_W'(g)),
         .ctl          (ctl),
         .rd_chain_in  (rd_chain[g]),
         .rd_chain_out (rd_chain[g+1])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef ASSERT_OFF
   a_empty_idx: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (front_ff == '0 && rear_ff == '0))
      else $error("Empty queue with nonzero indices.");

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (CNT_W'(front_ff) < eff_cap && CNT_W'(rear_ff) < eff_cap))
      else $error("Index beyond active capacity.");

   a_cfg_empties: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> (empty_ff && rsp_valid_ff == $past(rsp_valid_ff && !rsp_tready)))
      else $error("Capacity write did not empty the queue.");

   a_underflow_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_UNDERFLOW) |-> rsp_data_ff == UNDERFLOW_DATA)
      else $error("Underflow response without all-ones data.");

   a_push_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && !cfg_write && (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT))
      |=> (rsp_valid_ff && rsp_data_ff == '0))
      else $error("Push response carries nonzero data.");
`endif

endmodule

/* test/tb.sv */
// Self-checking testbench for circular_deque: directed and random push/pop traffic
// against an in-bench deque predictor, with capacity changes between phases.
// Depends on cdq_pkg and the circular_deque RTL.
module tb;
   import cdq_pkg::*;

   typedef struct {
      logic [DATA_W-1:0] data;
      status_type        status;
   } deque_result_type;

   class deque_scoreboard_type;
      logic [DATA_W-1:0] ring[DEPTH];
      int unsigned       front;
      int unsigned       rear;
      bit                empty;
      logic [CAP_W-1:0]  capacity;
      deque_result_type  pending_results[$];
      int                mismatches;

      function new();
         capacity = 5'd16;
         front = 0;
         rear = 0;
         empty = 1;
         mismatches = 0;
      endfunction

      function void load_capacity(logic [CAP_W-1:0] value);
         capacity = value;
         front = 0;
         rear = 0;
         empty = 1;
      endfunction

      function int unsigned active_capacity();
         if (capacity == 0) return 1;
         if (capacity > DEPTH) return DEPTH;
         return capacity;
      endfunction

      function int unsigned wrap_up(int unsigned i);
         return (i >= active_capacity() - 1) ? 0 : i + 1;
      endfunction

      function int unsigned wrap_down(int unsigned i);
         return (i == 0 || i >= active_capacity()) ? active_capacity() - 1 : i - 1;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("ERROR: %s", msg);
      endfunction

      // Applies one accepted request to the predicted deque and queues its result.
      function void note_request(kind_type kind, logic [DATA_W-1:0] value);
         deque_result_type r;
         r.data = '0;
         r.status = STATUS_OK;
         if (kind == KIND_PUSH_BACK || kind == KIND_PUSH_FRONT) begin
            if (!empty && wrap_up(rear) == front) begin
               r.status = STATUS_OVERFLOW;
            end else if (empty) begin
               front = 0;
               rear = 0;
               empty = 0;
               ring[0] = value;
            end else if (kind == KIND_PUSH_BACK) begin
               rear = wrap_up(rear);
               ring[rear % DEPTH] = value;
            end else begin
               front = wrap_down(front);
               ring[front % DEPTH] = value;
            end
         end else if (empty) begin
            r.data = UNDERFLOW_DATA;
            r.status = STATUS_UNDERFLOW;
         end else if (kind == KIND_POP_FRONT) begin
            r.data = ring[front % DEPTH];
            if (front == rear) load_capacity(capacity);
            else front = wrap_up(front);
         end else begin
            r.data = ring[rear % DEPTH];
            if (front == rear) load_capacity(capacity);
            else rear = wrap_down(rear);
         end
         pending_results.push_back(r);
      endfunction

      function void check_response(logic [DATA_W-1:0] data, logic [1:0] status);
         deque_result_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("unexpected response data=%h status=%0d", data, status));
         end else begin
            want = pending_results.pop_front();
            if (data !== want.data || status !== want.status)
               report($sformatf("expected data=%h status=%0d, got data=%h status=%0d",
                                want.data, want.status, data, status));
         end
      endfunction

      function void check_drained();
         while (pending_results.size() != 0) begin
            report($sformatf("missing response data=%h status=%0d",
                             pending_results[0].data, pending_results[0].status));
            void'(pending_results.pop_front());
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [CAP_W-1:0]  csr_data = '0;
   logic              req_tvalid = 0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic [1:0]        req_tuser = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [1:0]        rsp_tuser;

   deque_scoreboard_type sb = new();
   int burst_left = 0;
   bit gapless = 0;
   int stall_pct = 0;
   int stall_age = 0;
   logic [CAP_W-1:0] caps[8] = '{5'd2, 5'd15, 5'd16, 5'd17, 5'd31, 5'd3, 5'd1, 5'd0};

   circular_deque uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.load_capacity(csr_data);
         if (req_tvalid && req_tready) sb.note_request(kind_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
      end
   end

   // The response side changes its stall rate at random intervals.
   always @(posedge clock) begin
      if (stall_age == 0) begin
         case ($urandom_range(0, 4))
            0, 1: stall_pct <= 0;
            2: stall_pct <= 25;
            3: stall_pct <= 50;
            default: stall_pct <= 85;
         endcase
         stall_age <= $urandom_range(10, 60);
      end else begin
         stall_age <= stall_age - 1;
      end
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic issue(kind_type kind, logic [DATA_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = gapless ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1;
      req_tdata <= value;
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending_results.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_W-1:0] value);
      wait_drained();
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic kind_type pick_kind(int push_pct);
      if ($urandom_range(0, 99) < push_pct)
         return $urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
      return $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
   endfunction

   task automatic random_phase(logic [CAP_W-1:0] cap, int items, bit pause_midway);
      int seg_left;
      int push_pct;
      write_capacity(cap);
      gapless = ($urandom_range(0, 2) == 0);
      seg_left = 0;
      push_pct = 50;
      for (int i = 0; i < items; i++) begin
         if (pause_midway && i == items / 2) wait_drained();
         if (seg_left == 0) begin
            case ($urandom_range(0, 3))
               0, 1: push_pct = 85;
               2: push_pct = 15;
               default: push_pct = 50;
            endcase
            seg_left = $urandom_range(1, 2 * 16 + 2);
         end
         seg_left--;
         issue(pick_kind(push_pct), pick_value());
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 0;

      issue(KIND_POP_FRONT, 32'h1234_5678);
      issue(KIND_POP_BACK, 32'h0);
      issue(KIND_PUSH_BACK, 32'h7FFF_FFFF);
      issue(KIND_PUSH_FRONT, 32'h8000_0000);
      issue(KIND_PUSH_BACK, 32'hFFFF_FFFF);
      issue(KIND_PUSH_FRONT, 32'h0000_0000);
      issue(KIND_POP_FRONT, 32'h0);
      issue(KIND_POP_BACK, 32'h0);
      issue(KIND_POP_FRONT, 32'h0);
      issue(KIND_POP_BACK, 32'h0);
      issue(KIND_POP_BACK, 32'h0);

      write_capacity(5'd1);
      issue(KIND_PUSH_BACK, 32'h5A5A_5A5A);
      issue(KIND_PUSH_FRONT, 32'hA5A5_A5A5);
      issue(KIND_POP_FRONT, 32'h0);
      issue(KIND_POP_BACK, 32'h0);

      // A capacity of zero behaves as one.
      write_capacity(5'd0);
      issue(KIND_PUSH_FRONT, 32'h1);
      issue(KIND_PUSH_BACK, 32'h2);
      issue(KIND_POP_BACK, 32'h0);

      // Rewriting the capacity while entries are held empties the queue.
      write_capacity(5'd31);
      issue(KIND_PUSH_BACK, 32'h3);
      issue(KIND_PUSH_FRONT, 32'h4);
      write_capacity(5'd2);
      issue(KIND_POP_FRONT, 32'h0);
      issue(KIND_PUSH_FRONT, 32'h6);
      issue(KIND_PUSH_FRONT, 32'h7);
      issue(KIND_PUSH_FRONT, 32'h8);

      for (int phase = 0; phase < 10; phase++)
         random_phase(phase < 8 ? caps[phase] : CAP_W'($urandom_range(0, 31)), 40,
                      phase == 4);

      wait_drained();
      repeat (5) @(posedge clock);
      sb.check_drained();
      if (sb.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #4000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
